/* hdl/pixel_tone_blend_assert.svh */
// Assertion macros shared by the pixel tone blend RTL.
`ifndef PIXEL_TONE_BLEND_ASSERT_SVH
`define PIXEL_TONE_BLEND_ASSERT_SVH
`ifndef SYNTHESIS
`define PTB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pixel_tone_blend: same-cycle assertion failed");
`define PTB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pixel_tone_blend: next-cycle assertion failed");
`else
`define PTB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define PTB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/ptb_pkg.sv */
package ptb_pkg;

  typedef logic [7:0] chan_t;
  typedef logic [2:0][7:0] rgb_t;

  localparam int unsigned NumStages = 6;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 9;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_OPACITY    = 3'd0,
    CFG_BLEND_MODE = 3'd1,
    CFG_RED_TONE   = 3'd2,
    CFG_GREEN_TONE = 3'd3,
    CFG_BLUE_TONE  = 3'd4,
    CFG_SATURATION = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_BLEND = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_SUB   = 2'd2,
    MODE_KEEP  = 2'd3
  } blend_mode_e;

  localparam logic [14:0] LumaWr = 15'd30;
  localparam logic [14:0] LumaWg = 15'd59;
  localparam logic [14:0] LumaWb = 15'd11;
  // Reciprocal of 100 scaled by 2^21, rounded up; exact for sums below 43690.
  localparam logic [29:0] LumaRecip = 30'd20972;
  localparam int unsigned LumaShift = 21;

  localparam chan_t ChanMax = 8'd255;

  typedef struct packed {
    chan_t keep;
    chan_t add;
  } tone_coef_t;

  // Exact floor(num / 255) for num up to 65279.
  function automatic chan_t div255(input logic [15:0] num);
    logic [16:0] acc;
    acc = 17'(num) + 17'(num[15:8]) + 17'd1;
    return acc[15:8];
  endfunction

  // A tone t mixes the channel toward 255 (t > 0) or toward 0 (t < 0):
  // result = floor(c * keep / 255) + add.
  function automatic tone_coef_t tone_coef(input logic [8:0] tone);
    tone_coef_t coef;
    logic [8:0] mag;
    mag = 9'd0 - tone;
    coef.keep = ChanMax;
    coef.add  = 8'd0;
    if (tone[8] == 1'b0) begin
      coef.keep = ChanMax - tone[7:0];
      coef.add  = tone[7:0];
    end else if (mag[8]) begin
      coef.keep = 8'd0;
    end else begin
      coef.keep = ChanMax - mag[7:0];
    end
    return coef;
  endfunction

endpackage

/* hdl/ptb_if.sv */
interface ptb_pix_in_if;
  logic           valid;
  logic           ready;
  ptb_pkg::chan_t src_red;
  ptb_pkg::chan_t src_green;
  ptb_pkg::chan_t src_blue;
  ptb_pkg::chan_t src_alpha;
  ptb_pkg::chan_t dst_red;
  ptb_pkg::chan_t dst_green;
  ptb_pkg::chan_t dst_blue;
  ptb_pkg::chan_t dst_alpha;

  modport source (
    output valid, src_red, src_green, src_blue, src_alpha,
    output dst_red, dst_green, dst_blue, dst_alpha,
    input  ready
  );
  modport sink (
    input  valid, src_red, src_green, src_blue, src_alpha,
    input  dst_red, dst_green, dst_blue, dst_alpha,
    output ready
  );
endinterface

interface ptb_pix_out_if;
  logic           valid;
  logic           ready;
  ptb_pkg::chan_t out_red;
  ptb_pkg::chan_t out_green;
  ptb_pkg::chan_t out_blue;
  ptb_pkg::chan_t out_alpha;
  logic           written;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha, written,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha, written,
    output ready
  );
endinterface

interface ptb_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ptb_pkg::CfgIdxWidth-1:0]   index;
  logic [ptb_pkg::CfgDataWidth-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hdl/pixel_tone_blend.sv */
// Blends one source RGBA pixel into one destination RGBA pixel per clock
// while the output keeps taking results. The datapath is a six-stage
// pipeline that takes a new pair while earlier pairs are in flight; each
// stage holds at most one set of multiplies and at most two divide-by-255
// adders per channel. Ready is computed stage by stage, so bubbles close up
// and the input side keeps taking pixels while a finished result waits at
// the output, as long as some stage is empty. The configuration port is
// always ready; registers are opacity (0), blend_mode (1), red tone (2),
// green tone (3), blue tone (4) and saturation (5), and a write to any
// other index is dropped. Write them only while the pipeline is empty.
`include "pixel_tone_blend_assert.svh"

module pixel_tone_blend (
  input logic           clk_i,
  input logic           rst_ni,
  ptb_pix_in_if.sink    pix_i,
  ptb_pix_out_if.source pix_o,
  ptb_cfg_if.sink       cfg_i
);

  typedef struct packed {
    logic           written;
    ptb_pkg::rgb_t  src;
    ptb_pkg::rgb_t  dst;
    ptb_pkg::chan_t dst_alpha;
    ptb_pkg::chan_t src_alpha;
    logic [14:0]    luma_sum;
    logic [15:0]    ea_prod;
  } st1_t;

  typedef struct packed {
    logic           written;
    ptb_pkg::rgb_t  src;
    ptb_pkg::rgb_t  dst;
    ptb_pkg::chan_t dst_alpha;
    ptb_pkg::chan_t src_alpha;
    ptb_pkg::chan_t luma;
    ptb_pkg::chan_t ea;
  } st2_t;

  typedef struct packed {
    logic            written;
    ptb_pkg::rgb_t   dst;
    ptb_pkg::chan_t  dst_alpha;
    ptb_pkg::chan_t  ea;
    logic [2:0][15:0] num;
  } st3_t;

  typedef struct packed {
    logic            written;
    ptb_pkg::rgb_t   dst;
    ptb_pkg::chan_t  dst_alpha;
    ptb_pkg::chan_t  ea;
    logic [2:0][15:0] blend_num;
    logic [2:0][15:0] term_prod;
  } st5_t;

  typedef struct packed {
    logic           written;
    ptb_pkg::rgb_t  color;
    ptb_pkg::chan_t alpha;
  } st6_t;

  localparam int unsigned NStages = ptb_pkg::NumStages;

  ptb_pkg::chan_t              opacity_q;
  ptb_pkg::blend_mode_e        mode_q;
  logic [2:0][8:0]             tone_q;
  ptb_pkg::chan_t              saturation_q;
  ptb_pkg::tone_coef_t [2:0]   coef;

  logic [NStages-1:0] vld_q;
  logic [NStages-1:0] adv;

  st1_t s1_d, s1_q;
  st2_t s2_d, s2_q;
  st3_t s3_d, s3_q;
  st3_t s4_d, s4_q;
  st5_t s5_d, s5_q;
  st6_t s6_d, s6_q;

  logic [29:0] luma_prod;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opacity_q    <= ptb_pkg::ChanMax;
      mode_q       <= ptb_pkg::MODE_BLEND;
      tone_q       <= '0;
      saturation_q <= ptb_pkg::ChanMax;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        ptb_pkg::CFG_OPACITY:    opacity_q    <= cfg_i.data[7:0];
        ptb_pkg::CFG_BLEND_MODE: mode_q       <= ptb_pkg::blend_mode_e'(cfg_i.data[1:0]);
        ptb_pkg::CFG_RED_TONE:   tone_q[0]    <= cfg_i.data;
        ptb_pkg::CFG_GREEN_TONE: tone_q[1]    <= cfg_i.data;
        ptb_pkg::CFG_BLUE_TONE:  tone_q[2]    <= cfg_i.data;
        ptb_pkg::CFG_SATURATION: saturation_q <= cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      coef[c] = ptb_pkg::tone_coef(tone_q[c]);
    end
  end

  // A stage loads when it is empty or its content moves on.
  always_comb begin
    adv[NStages-1] = !vld_q[NStages-1] || pix_o.ready;
    for (int k = NStages - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign pix_i.ready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= pix_i.valid;
      end
      for (int k = 1; k < NStages; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_comb begin
    s1_d.written   = pix_i.src_alpha != 8'd0;
    s1_d.src       = {pix_i.src_blue, pix_i.src_green, pix_i.src_red};
    s1_d.dst       = {pix_i.dst_blue, pix_i.dst_green, pix_i.dst_red};
    s1_d.dst_alpha = pix_i.dst_alpha;
    s1_d.src_alpha = pix_i.src_alpha;
    s1_d.luma_sum  = 15'(pix_i.src_red) * ptb_pkg::LumaWr
                   + 15'(pix_i.src_green) * ptb_pkg::LumaWg
                   + 15'(pix_i.src_blue) * ptb_pkg::LumaWb;
    s1_d.ea_prod   = 16'(pix_i.src_alpha) * 16'(opacity_q);
  end

  always_comb begin
    luma_prod      = 30'(s1_q.luma_sum) * ptb_pkg::LumaRecip;
    s2_d.written   = s1_q.written;
    s2_d.src       = s1_q.src;
    s2_d.dst       = s1_q.dst;
    s2_d.dst_alpha = s1_q.dst_alpha;
    s2_d.src_alpha = s1_q.src_alpha;
    s2_d.luma      = 8'(luma_prod >> ptb_pkg::LumaShift);
    s2_d.ea        = ptb_pkg::div255(s1_q.ea_prod);
  end

  always_comb begin
    s3_d.written   = s2_q.written;
    s3_d.dst       = s2_q.dst;
    s3_d.dst_alpha = s2_q.dst_alpha;
    s3_d.ea        = s2_q.ea;
    for (int c = 0; c < 3; c++) begin
      s3_d.num[c] = 16'(s2_q.luma) * 16'(ptb_pkg::ChanMax - saturation_q)
                  + 16'(s2_q.src[c]) * 16'(saturation_q);
    end
  end

  always_comb begin
    s4_d.written   = s3_q.written;
    s4_d.dst       = s3_q.dst;
    s4_d.dst_alpha = s3_q.dst_alpha;
    s4_d.ea        = s3_q.ea;
    for (int c = 0; c < 3; c++) begin
      s4_d.num[c] = 16'(ptb_pkg::div255(s3_q.num[c])) * 16'(coef[c].keep);
    end
  end

  always_comb begin
    ptb_pkg::chan_t toned;
    s5_d.written   = s4_q.written;
    s5_d.dst       = s4_q.dst;
    s5_d.dst_alpha = s4_q.dst_alpha;
    s5_d.ea        = s4_q.ea;
    for (int c = 0; c < 3; c++) begin
      toned = ptb_pkg::div255(s4_q.num[c]) + coef[c].add;
      s5_d.blend_num[c] = 16'(s4_q.dst[c]) * 16'(ptb_pkg::ChanMax - s4_q.ea)
                        + 16'(toned) * 16'(s4_q.ea);
      s5_d.term_prod[c] = 16'(toned) * 16'(s4_q.ea);
    end
  end

  always_comb begin
    ptb_pkg::chan_t term;
    logic [8:0]     sum;
    s6_d.written = s5_q.written;
    s6_d.alpha   = (s5_q.dst_alpha > s5_q.ea) ? s5_q.dst_alpha : s5_q.ea;
    for (int c = 0; c < 3; c++) begin
      term = ptb_pkg::div255(s5_q.term_prod[c]);
      sum  = 9'(s5_q.dst[c]) + 9'(term);
      unique case (mode_q)
        ptb_pkg::MODE_BLEND: s6_d.color[c] = ptb_pkg::div255(s5_q.blend_num[c]);
        ptb_pkg::MODE_ADD:   s6_d.color[c] = sum[8] ? ptb_pkg::ChanMax : sum[7:0];
        ptb_pkg::MODE_SUB:   s6_d.color[c] = (term >= s5_q.dst[c]) ? 8'd0
                                                                   : s5_q.dst[c] - term;
        ptb_pkg::MODE_KEEP:  s6_d.color[c] = s5_q.dst[c];
        default:             s6_d.color[c] = s5_q.dst[c];
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) s1_q <= s1_d;
    if (adv[1]) s2_q <= s2_d;
    if (adv[2]) s3_q <= s3_d;
    if (adv[3]) s4_q <= s4_d;
    if (adv[4]) s5_q <= s5_d;
    if (adv[5]) s6_q <= s6_d;
  end

  assign pix_o.valid     = vld_q[NStages-1];
  assign pix_o.out_red   = s6_q.color[0];
  assign pix_o.out_green = s6_q.color[1];
  assign pix_o.out_blue  = s6_q.color[2];
  assign pix_o.out_alpha = s6_q.alpha;
  assign pix_o.written   = s6_q.written;

  `PTB_ASSERT_IMPL(a_ready_when_out_free, clk_i, rst_ni, !vld_q[NStages-1], pix_i.ready)
  `PTB_ASSERT_NEXT(a_no_item_lost, clk_i, rst_ni, 1'b1,
                   $countones(vld_q) == $past($countones(vld_q))
                   + $past(pix_i.valid && pix_i.ready) - $past(pix_o.valid && pix_o.ready))
  `PTB_ASSERT_IMPL(a_ea_bounded, clk_i, rst_ni, vld_q[1], s2_q.ea <= s2_q.src_alpha)
  `PTB_ASSERT_IMPL(a_unwritten_zero_ea, clk_i, rst_ni, vld_q[1] && !s2_q.written, s2_q.ea == 8'd0)

endmodule

/* verif/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    ptb_pkg::chan_t src_red;
    ptb_pkg::chan_t src_green;
    ptb_pkg::chan_t src_blue;
    ptb_pkg::chan_t src_alpha;
    ptb_pkg::chan_t dst_red;
    ptb_pkg::chan_t dst_green;
    ptb_pkg::chan_t dst_blue;
    ptb_pkg::chan_t dst_alpha;
  } pix_pair_t;

  typedef struct packed {
    ptb_pkg::chan_t red;
    ptb_pkg::chan_t green;
    ptb_pkg::chan_t blue;
    ptb_pkg::chan_t alpha;
    logic           written;
  } pix_out_t;

  localparam logic [ptb_pkg::CfgIdxWidth-1:0]  CfgIdxSpareLo = 3'd6;
  localparam logic [ptb_pkg::CfgIdxWidth-1:0]  CfgIdxSpareHi = 3'd7;
  localparam logic [ptb_pkg::CfgDataWidth-1:0] ToneFullUp    = 9'h0ff;
  localparam logic [ptb_pkg::CfgDataWidth-1:0] ToneFullDown  = 9'h101;
  localparam logic [ptb_pkg::CfgDataWidth-1:0] ToneOverDown  = 9'h100;
  localparam int unsigned                      NumPixels     = 1450;

  class blend_checker;
    ptb_pkg::chan_t       opacity;
    ptb_pkg::chan_t       saturation;
    ptb_pkg::blend_mode_e mode;
    logic [8:0]           tone [3];
    pix_out_t             pending_pixels [$];
    int unsigned          errors;
    int unsigned          checked;
    int unsigned          zero_alpha;
    int unsigned          keep_mode;

    function new();
      opacity    = ptb_pkg::ChanMax;
      saturation = ptb_pkg::ChanMax;
      mode       = ptb_pkg::MODE_BLEND;
      tone       = '{default: 9'd0};
      errors     = 0;
      checked    = 0;
      zero_alpha = 0;
      keep_mode  = 0;
    endfunction

    function void write_reg(logic [ptb_pkg::CfgIdxWidth-1:0] idx,
                            logic [ptb_pkg::CfgDataWidth-1:0] data);
      case (idx)
        ptb_pkg::CFG_OPACITY:    opacity = data[7:0];
        ptb_pkg::CFG_BLEND_MODE: mode = ptb_pkg::blend_mode_e'(data[1:0]);
        ptb_pkg::CFG_RED_TONE:   tone[0] = data;
        ptb_pkg::CFG_GREEN_TONE: tone[1] = data;
        ptb_pkg::CFG_BLUE_TONE:  tone[2] = data;
        ptb_pkg::CFG_SATURATION: saturation = data[7:0];
        default: ;
      endcase
    endfunction

    function int unsigned mix(int unsigned s, int unsigned d, int unsigned a);
      if (a >= 255) return s;
      if (a == 0) return d;
      return (d * (255 - a) + s * a) / 255;
    endfunction

    function int unsigned toned(int unsigned c, logic [8:0] t);
      int unsigned mag;
      mag = 512 - int'(t);
      if (t == 9'd0) return c;
      if (!t[8]) return mix(255, c, t);
      if (mag > 255) mag = 255;
      return mix(0, c, mag);
    endfunction

    function int unsigned combine(int unsigned s, int unsigned d, int unsigned ea);
      int unsigned term;
      term = (s * ea) / 255;
      case (mode)
        ptb_pkg::MODE_BLEND: return mix(s, d, ea);
        ptb_pkg::MODE_ADD:   return (d + term > 255) ? 255 : d + term;
        ptb_pkg::MODE_SUB:   return (term >= d) ? 0 : d - term;
        default:             return d;
      endcase
    endfunction

    function pix_out_t blend_pixel(pix_pair_t p);
      pix_out_t    o;
      int unsigned c [3];
      int unsigned d [3];
      int unsigned ea;
      int unsigned luma;
      o.red     = p.dst_red;
      o.green   = p.dst_green;
      o.blue    = p.dst_blue;
      o.alpha   = p.dst_alpha;
      o.written = 1'b0;
      if (p.src_alpha == 8'd0) return o;
      c = '{p.src_red, p.src_green, p.src_blue};
      d = '{p.dst_red, p.dst_green, p.dst_blue};
      ea = int'(p.src_alpha);
      if (opacity != ptb_pkg::ChanMax) ea = (ea * int'(opacity)) / 255;
      if (saturation != ptb_pkg::ChanMax) begin
        luma = (30 * c[0] + 59 * c[1] + 11 * c[2]) / 100;
        for (int i = 0; i < 3; i++) c[i] = mix(c[i], luma, saturation);
      end
      for (int i = 0; i < 3; i++) c[i] = combine(toned(c[i], tone[i]), d[i], ea);
      o.red     = ptb_pkg::chan_t'(c[0]);
      o.green   = ptb_pkg::chan_t'(c[1]);
      o.blue    = ptb_pkg::chan_t'(c[2]);
      o.alpha   = (int'(p.dst_alpha) > ea) ? p.dst_alpha : ptb_pkg::chan_t'(ea);
      o.written = 1'b1;
      return o;
    endfunction

    function void note_pair(pix_pair_t p);
      pending_pixels.push_back(blend_pixel(p));
      if (p.src_alpha == 8'd0) zero_alpha++;
      else if (mode == ptb_pkg::MODE_KEEP) keep_mode++;
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: pixel %0d %s expected %0d, got %0d", $time, checked, name, want, got);
        errors++;
      end
    endfunction

    function void check_pixel(pix_out_t got);
      pix_out_t want;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, got %h", $time, got);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      compare_field("red", want.red, got.red);
      compare_field("green", want.green, got.green);
      compare_field("blue", want.blue, got.blue);
      compare_field("alpha", want.alpha, got.alpha);
      compare_field("written", want.written, got.written);
      checked++;
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  bit           steady;
  int unsigned  settings;
  blend_checker blend = new();

  ptb_pix_in_if  pix_in ();
  ptb_pix_out_if pix_out ();
  ptb_cfg_if     cfg ();

  pixel_tone_blend dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .pix_i (pix_in),
    .pix_o (pix_out),
    .cfg_i (cfg)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic ptb_pkg::chan_t pick_chan();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return ptb_pkg::ChanMax;
      default: return ptb_pkg::chan_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pix_pair_t pick_pair();
    pix_pair_t p;
    p = {pick_chan(), pick_chan(), pick_chan(), pick_chan(),
         pick_chan(), pick_chan(), pick_chan(), pick_chan()};
    case ($urandom_range(0, 9))
      0, 1: p.src_alpha = 8'd0;
      2, 3: p.src_alpha = ptb_pkg::ChanMax;
      default: p.src_alpha = ptb_pkg::chan_t'($urandom_range(1, 254));
    endcase
    return p;
  endfunction

  function automatic pix_pair_t pair_of(ptb_pkg::chan_t sr, ptb_pkg::chan_t sg,
                                        ptb_pkg::chan_t sb, ptb_pkg::chan_t sa,
                                        ptb_pkg::chan_t dr, ptb_pkg::chan_t dg,
                                        ptb_pkg::chan_t db, ptb_pkg::chan_t da);
    pix_pair_t p;
    p = {sr, sg, sb, sa, dr, dg, db, da};
    return p;
  endfunction

  function automatic logic [ptb_pkg::CfgDataWidth-1:0] pick_level();
    logic [ptb_pkg::CfgDataWidth-1:0] v;
    case ($urandom_range(0, 3))
      0: v = 9'd0;
      1: v = 9'd255;
      default: v = 9'($urandom_range(0, 255));
    endcase
    v[8] = 1'($urandom_range(0, 1));
    return v;
  endfunction

  function automatic logic [ptb_pkg::CfgDataWidth-1:0] pick_tone();
    case ($urandom_range(0, 7))
      0: return 9'd0;
      1: return ToneFullUp;
      2: return ToneFullDown;
      3: return ToneOverDown;
      default: return 9'($urandom_range(0, 511));
    endcase
  endfunction

  task automatic send_pair(input pix_pair_t p);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      pix_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_in.valid     <= 1'b1;
    pix_in.src_red   <= p.src_red;
    pix_in.src_green <= p.src_green;
    pix_in.src_blue  <= p.src_blue;
    pix_in.src_alpha <= p.src_alpha;
    pix_in.dst_red   <= p.dst_red;
    pix_in.dst_green <= p.dst_green;
    pix_in.dst_blue  <= p.dst_blue;
    pix_in.dst_alpha <= p.dst_alpha;
    do @(posedge clk); while (!pix_in.ready);
    blend.note_pair(p);
  endtask

  task automatic write_reg(input logic [ptb_pkg::CfgIdxWidth-1:0] idx,
                           input logic [ptb_pkg::CfgDataWidth-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    blend.write_reg(idx, data);
  endtask

  // Registers change only once the pipeline has drained.
  task automatic apply_setting(input logic [ptb_pkg::CfgDataWidth-1:0] op, md,
                               input logic [ptb_pkg::CfgDataWidth-1:0] t_r, t_g, t_b, sat,
                               input bit spare);
    ptb_pkg::cfg_idx_e regs [6] = '{ptb_pkg::CFG_OPACITY, ptb_pkg::CFG_BLEND_MODE,
                                    ptb_pkg::CFG_RED_TONE, ptb_pkg::CFG_GREEN_TONE,
                                    ptb_pkg::CFG_BLUE_TONE, ptb_pkg::CFG_SATURATION};
    logic [ptb_pkg::CfgDataWidth-1:0] vals [6];
    vals = '{op, md, t_r, t_g, t_b, sat};
    pix_in.valid <= 1'b0;
    while (blend.pending_pixels.size() != 0) @(posedge clk);
    repeat (ptb_pkg::NumStages + 2) @(posedge clk);
    for (int i = 0; i < 6; i++) write_reg(regs[i], vals[i]);
    if (spare) begin
      write_reg($urandom_range(0, 1) ? CfgIdxSpareHi : CfgIdxSpareLo,
                9'($urandom_range(0, 511)));
    end
    cfg.valid <= 1'b0;
    settings++;
  endtask

  initial begin
    pix_out_t    got;
    int unsigned stall;
    stall = 0;
    pix_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && pix_out.valid && pix_out.ready) begin
        got.red     = pix_out.out_red;
        got.green   = pix_out.out_green;
        got.blue    = pix_out.out_blue;
        got.alpha   = pix_out.out_alpha;
        got.written = pix_out.written;
        blend.check_pixel(got);
      end
      if (stall != 0) begin
        pix_out.ready <= 1'b0;
        stall--;
      end else begin
        pix_out.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  initial begin
    #10ms;
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    int unsigned                      sent;
    int unsigned                      len;
    logic [ptb_pkg::CfgDataWidth-1:0] md;
    steady   = 1'b0;
    settings = 0;
    rst_n            <= 1'b0;
    pix_in.valid     <= 1'b0;
    pix_in.src_red   <= '0;
    pix_in.src_green <= '0;
    pix_in.src_blue  <= '0;
    pix_in.src_alpha <= '0;
    pix_in.dst_red   <= '0;
    pix_in.dst_green <= '0;
    pix_in.dst_blue  <= '0;
    pix_in.dst_alpha <= '0;
    cfg.valid        <= 1'b0;
    cfg.index        <= '0;
    cfg.data         <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register values straight out of reset.
    send_pair(pair_of(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(pair_of(255, 255, 255, 255, 255, 255, 255, 255));
    send_pair(pair_of(200, 100, 50, 0, 12, 34, 56, 78));
    send_pair(pair_of(8'h55, 8'haa, 8'h55, 8'haa, 8'haa, 8'h55, 8'haa, 8'h55));

    // Zero opacity leaves a written pixel with the destination colour.
    apply_setting(9'd0, 9'(ptb_pkg::MODE_BLEND), 9'd0, 9'd0, 9'd0, 9'd255, 1'b0);
    send_pair(pair_of(255, 0, 128, 200, 10, 20, 30, 40));
    send_pair(pair_of(1, 2, 3, 1, 250, 251, 252, 0));

    apply_setting(9'd128, 9'(ptb_pkg::MODE_ADD), ToneFullUp, ToneFullDown, ToneOverDown,
                  9'd0, 1'b0);
    send_pair(pair_of(255, 255, 255, 255, 200, 100, 0, 10));
    send_pair(pair_of(90, 160, 30, 128, 0, 255, 128, 255));
    send_pair(pair_of(0, 0, 0, 1, 255, 255, 255, 0));
    send_pair(pair_of(8'haa, 8'h55, 8'haa, 8'h55, 8'h55, 8'haa, 8'h55, 8'haa));

    apply_setting(9'h1c0, 9'(ptb_pkg::MODE_SUB), 9'd77, 9'h1b3, 9'd0, 9'd200, 1'b0);
    send_pair(pair_of(255, 255, 255, 255, 0, 0, 0, 0));
    send_pair(pair_of(120, 200, 40, 255, 255, 128, 60, 90));
    send_pair(pair_of(30, 30, 30, 77, 0, 255, 1, 0));

    apply_setting(9'd255, 9'(ptb_pkg::MODE_KEEP), 9'h040, 9'h1c0, ToneFullUp, 9'd60, 1'b1);
    send_pair(pair_of(255, 0, 255, 128, 11, 22, 33, 44));
    send_pair(pair_of(0, 0, 0, 0, 99, 98, 97, 96));
    send_pair(pair_of(5, 6, 7, 255, 200, 201, 202, 10));

    apply_setting(9'd255, 9'(ptb_pkg::MODE_BLEND), 9'd0, 9'd0, 9'd0, 9'd255, 1'b1);
    send_pair(pair_of(128, 64, 32, 200, 16, 8, 4, 2));
    send_pair(pair_of(255, 255, 255, 1, 0, 0, 0, 0));

    sent = 0;
    while (sent < NumPixels) begin
      md      = 9'($urandom_range(0, 511));
      md[1:0] = ($urandom_range(0, 7) == 0)
                ? ptb_pkg::MODE_KEEP
                : 2'($urandom_range(ptb_pkg::MODE_BLEND, ptb_pkg::MODE_SUB));
      apply_setting(pick_level(), md, pick_tone(), pick_tone(), pick_tone(), pick_level(),
                    $urandom_range(0, 3) == 0);
      steady = ($urandom_range(0, 4) == 0);
      len    = $urandom_range(20, 80);
      repeat (len) begin
        if (blend.pending_pixels.size() != 0 && $urandom_range(0, 149) == 0) begin
          pix_in.valid <= 1'b0;
          while (blend.pending_pixels.size() != 0) @(posedge clk);
        end
        send_pair(pick_pair());
        sent++;
      end
    end
    pix_in.valid <= 1'b0;
    steady = 1'b0;

    while (blend.pending_pixels.size() != 0) @(posedge clk);
    repeat (ptb_pkg::NumStages * 4) @(posedge clk);
    $display("tb: %0d pixel results checked across %0d register settings",
             blend.checked, settings);
    $display("tb: %0d pairs had zero source alpha, %0d blended in keep mode",
             blend.zero_alpha, blend.keep_mode);
    if (blend.errors == 0 && blend.pending_pixels.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
